[sv/ptsa_pkg.sv]
// Shared types and constants of the PWM timer share allocator.
// No dependencies; used by every module of the block.
package ptsa_pkg;

  // Field widths fixed by the request and result formats
  localparam int SRC_W     = 27;
  localparam int FREQ_W    = 26;
  localparam int RES_W     = 4;
  localparam int DUTY_W    = 16;
  localparam int CHAN_W    = 4;
  localparam int ACT_W     = 2;
  localparam int TIDX_W    = 2;
  localparam int DIV_W     = 18;
  localparam int DWORD_W   = 19;
  localparam int MAXD_W    = 15;

  // Resolution and fixed-point settings
  localparam int MAX_RES   = 14;
  localparam int DUTY_FRAC = 4;
  localparam int FRAC_BITS = 8;

  // Divider geometry: (src << 8) / (freq << res)
  localparam int NUM_W = SRC_W + FRAC_BITS;
  localparam int DEN_W = FREQ_W + MAX_RES;
  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [DIV_W-1:0] DIV_MIN   = DIV_W'(1) << FRAC_BITS;
  localparam logic [SRC_W-1:0] SRC_RESET = SRC_W'(40000000);

  // Request kinds
  localparam logic [ACT_W-1:0] ACT_INIT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DUTY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_NOFIT = 2'd2,
    STAT_IDLE  = 2'd3
  } ptsa_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } ptsa_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic emit;
  } ptsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } ptsa_stat_t;

endpackage

[sv/ptsa_div.sv]
// Restoring divider, one quotient bit per cycle, for the timer clock divider.
// Depends on ptsa_pkg for operand widths.
module ptsa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptsa_pkg::NUM_W-1:0]    num_i,
  input  logic [ptsa_pkg::DEN_W-1:0]    den_i,
  output logic                          busy_o,
  output logic [ptsa_pkg::DIV_W-1:0]    quo_o,
  output logic                          ovf_o
);

  logic [ptsa_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [ptsa_pkg::NUM_W-1:0] num_q;
  logic [ptsa_pkg::DEN_W-1:0] den_q;
  logic [ptsa_pkg::DIV_W-1:0] quo_q;
  logic                       ovf_q;
  logic [ptsa_pkg::CNT_W-1:0] cnt_q;
  logic                       busy_q;
  logic [ptsa_pkg::REM_W-1:0] shifted;
  logic [ptsa_pkg::REM_W-1:0] diff;
  logic                       ge;

  // Trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem_q, num_q[ptsa_pkg::NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[ptsa_pkg::DEN_W-1:0] : shifted[ptsa_pkg::DEN_W-1:0];
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ptsa_pkg::CNT_W'(ptsa_pkg::NUM_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operands and partial results; keep low quotient bits, flag any lost above
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[ptsa_pkg::NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[ptsa_pkg::DIV_W-2:0], ge};
      ovf_q <= ovf_q | quo_q[ptsa_pkg::DIV_W-1];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

[sv/ptsa_datapath.sv]
// Datapath: request register, timer and channel tables, divider, result register.
// Depends on ptsa_pkg and ptsa_div.
module ptsa_datapath #(
  parameter int NUM_TIMERS   = 4,
  parameter int NUM_CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptsa_pkg::ptsa_cmd_t             cmd_i,
  output ptsa_pkg::ptsa_stat_t            stat_o,
  input  logic                            cfg_we_i,
  input  logic [ptsa_pkg::SRC_W-1:0]      cfg_data_i,
  input  logic [ptsa_pkg::ACT_W-1:0]      action_i,
  input  logic [ptsa_pkg::CHAN_W-1:0]     channel_i,
  input  logic [ptsa_pkg::FREQ_W-1:0]     freq_hz_i,
  input  logic [ptsa_pkg::RES_W-1:0]      res_bits_i,
  input  logic [ptsa_pkg::DUTY_W-1:0]     duty_i,
  input  logic                            idle_high_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output ptsa_pkg::ptsa_status_e          status_o,
  output logic [ptsa_pkg::TIDX_W-1:0]     timer_index_o,
  output logic                            new_timer_o,
  output logic [ptsa_pkg::DIV_W-1:0]      divider_o,
  output logic [ptsa_pkg::DWORD_W-1:0]    duty_word_o,
  output logic [ptsa_pkg::MAXD_W-1:0]     max_duty_o,
  output logic                            stop_level_o
);

  localparam int TI_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MX_W  = ptsa_pkg::DUTY_W + 1;
  localparam int DSH_W = MX_W + ptsa_pkg::DUTY_FRAC;

  // Request register
  logic [ptsa_pkg::ACT_W-1:0]  req_action_q;
  logic [ptsa_pkg::CHAN_W-1:0] req_channel_q;
  logic [ptsa_pkg::FREQ_W-1:0] req_freq_q;
  logic [ptsa_pkg::RES_W-1:0]  req_res_q;
  logic [ptsa_pkg::DUTY_W-1:0] req_duty_q;
  logic                        req_idle_q;

  // Configuration and tables
  logic [ptsa_pkg::SRC_W-1:0]  src_q;
  logic [ptsa_pkg::FREQ_W-1:0] tfreq_q [NUM_TIMERS];
  logic [ptsa_pkg::RES_W-1:0]  tres_q  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]       used_q;
  logic [ptsa_pkg::RES_W-1:0]  chan_res_q [NUM_CHANNELS];

  // Result register
  logic                        out_valid_q, out_valid_d;
  ptsa_pkg::ptsa_status_e      status_q;
  logic [ptsa_pkg::TIDX_W-1:0] tidx_q;
  logic                        new_q;
  logic [ptsa_pkg::DIV_W-1:0]  div_q;
  logic [ptsa_pkg::DWORD_W-1:0] dword_q;
  logic [ptsa_pkg::MAXD_W-1:0] maxd_q;
  logic                        lvl_q;

  // Decode and result logic
  logic                        ch_ok, args_ok;
  logic [CH_W-1:0]             ch_idx;
  logic [ptsa_pkg::RES_W-1:0]  cur_res, new_res;
  logic [NUM_TIMERS-1:0]       hit_vec;
  logic                        hit_any, free_any;
  logic [TI_W-1:0]             hit_idx, free_idx;
  logic                        div_busy, div_ovf, q_ok;
  logic [ptsa_pkg::DIV_W-1:0]  div_quo;
  logic [ptsa_pkg::DEN_W-1:0]  den;
  logic [MX_W-1:0]             mx_cur, duty_cl;
  logic [DSH_W-1:0]            duty_sh;
  logic [ptsa_pkg::MAXD_W:0]   max_new;
  logic [TI_W+1:0]             tidx_ext;
  ptsa_pkg::ptsa_status_e      res_status;
  logic [TI_W-1:0]             res_tidx;
  logic                        res_new, res_lvl, commit_chan, claim;
  logic [ptsa_pkg::DIV_W-1:0]  res_div;
  logic [ptsa_pkg::DWORD_W-1:0] res_dword;

  // Latch the accepted request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_action_q  <= action_i;
      req_channel_q <= channel_i;
      req_freq_q    <= freq_hz_i;
      req_res_q     <= res_bits_i;
      req_duty_q    <= duty_i;
      req_idle_q    <= idle_high_i;
    end
  end

  // Channel and argument checks
  always_comb begin
    ch_ok   = {1'b0, req_channel_q} < (ptsa_pkg::CHAN_W + 1)'(NUM_CHANNELS);
    ch_idx  = req_channel_q[CH_W-1:0];
    cur_res = ch_ok ? chan_res_q[ch_idx] : '0;
    args_ok = ch_ok && (req_freq_q != '0) && (req_res_q != '0)
              && (req_res_q <= ptsa_pkg::RES_W'(ptsa_pkg::MAX_RES));
  end

  // Match running timers and find the lowest free one
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int t = NUM_TIMERS - 1; t >= 0; t--) begin
      hit_vec[t] = used_q[t] && (tfreq_q[t] == req_freq_q) && (tres_q[t] == req_res_q);
      if (hit_vec[t]) begin
        hit_idx = TI_W'(t);
      end
      if (!used_q[t]) begin
        free_idx = TI_W'(t);
      end
    end
    hit_any  = |hit_vec;
    free_any = ~&used_q;
  end

  // Divider operands
  assign den = ptsa_pkg::DEN_W'(req_freq_q) << req_res_q;

  ptsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   ({src_q, {ptsa_pkg::FRAC_BITS{1'b0}}}),
    .den_i   (den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf)
  );

  assign q_ok = !div_ovf && (div_quo >= ptsa_pkg::DIV_MIN);

  // Clamp duty to the channel range and add fractional bits
  always_comb begin
    mx_cur  = MX_W'(1) << cur_res;
    duty_cl = ({1'b0, req_duty_q} > mx_cur) ? mx_cur : {1'b0, req_duty_q};
    duty_sh = {duty_cl, {ptsa_pkg::DUTY_FRAC{1'b0}}};
  end

  // Result of the request
  always_comb begin
    res_status  = ptsa_pkg::STAT_BAD;
    res_tidx    = '0;
    res_new     = 1'b0;
    res_div     = '0;
    res_dword   = '0;
    res_lvl     = 1'b0;
    commit_chan = 1'b0;
    claim       = 1'b0;
    unique case (req_action_q)
      ptsa_pkg::ACT_INIT: begin
        if (!args_ok) begin
          res_status = ptsa_pkg::STAT_BAD;
        end else if (hit_any) begin
          res_status  = ptsa_pkg::STAT_OK;
          res_tidx    = hit_idx;
          commit_chan = 1'b1;
        end else if (!q_ok || !free_any) begin
          res_status = ptsa_pkg::STAT_NOFIT;
        end else begin
          res_status  = ptsa_pkg::STAT_OK;
          res_tidx    = free_idx;
          res_new     = 1'b1;
          res_div     = div_quo;
          claim       = 1'b1;
          commit_chan = 1'b1;
        end
      end
      ptsa_pkg::ACT_DUTY: begin
        if (!ch_ok) begin
          res_status = ptsa_pkg::STAT_BAD;
        end else if (cur_res == '0) begin
          res_status = ptsa_pkg::STAT_IDLE;
        end else begin
          res_status = ptsa_pkg::STAT_OK;
          res_dword  = duty_sh[ptsa_pkg::DWORD_W-1:0];
        end
      end
      ptsa_pkg::ACT_STOP: begin
        if (ch_ok) begin
          res_status = ptsa_pkg::STAT_OK;
          res_lvl    = req_idle_q;
        end
      end
      default: begin
        res_status = ptsa_pkg::STAT_BAD;
      end
    endcase
    new_res  = commit_chan ? req_res_q : cur_res;
    max_new  = (ch_ok && new_res != '0) ? ((ptsa_pkg::MAXD_W + 1)'(1) << new_res) : '0;
    tidx_ext = {2'b00, res_tidx};
  end

  // Configuration register and tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= ptsa_pkg::SRC_RESET;
      used_q <= '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        tfreq_q[t] <= '0;
        tres_q[t]  <= '0;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_res_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        src_q <= cfg_data_i;
      end
      if (cmd_i.emit && claim) begin
        used_q[free_idx]  <= 1'b1;
        tfreq_q[free_idx] <= req_freq_q;
        tres_q[free_idx]  <= req_res_q;
      end
      if (cmd_i.emit && commit_chan) begin
        chan_res_q[ch_idx] <= req_res_q;
      end
    end
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= res_status;
      tidx_q   <= tidx_ext[ptsa_pkg::TIDX_W-1:0];
      new_q    <= res_new;
      div_q    <= res_div;
      dword_q  <= res_dword;
      maxd_q   <= max_new[ptsa_pkg::MAXD_W-1:0];
      lvl_q    <= res_lvl;
    end
  end

  always_comb begin
    stat_o.need_div = (req_action_q == ptsa_pkg::ACT_INIT) && args_ok && !hit_any;
    stat_o.div_busy = div_busy;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign timer_index_o = tidx_q;
  assign new_timer_o   = new_q;
  assign divider_o     = div_q;
  assign duty_word_o   = dword_q;
  assign max_duty_o    = maxd_q;
  assign stop_level_o  = lvl_q;

  // A started division raises the divider's busy flag
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> div_busy)
    else $error("divider did not start");

  // A timer is claimed only after the division and only when one is free
  a_claim_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && claim) |-> (!div_busy && free_any && q_ok))
    else $error("timer claimed without a finished division or a free timer");

  // A result is never written over one that is still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overrun");

endmodule

[sv/ptsa_ctrl.sv]
// Controller state machine: accept, evaluate, divide, deliver.
// Depends on ptsa_pkg for the state, command and status types.
module ptsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ptsa_pkg::ptsa_stat_t stat_i,
  output ptsa_pkg::ptsa_cmd_t  cmd_o
);

  ptsa_pkg::ptsa_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.emit      = 1'b0;
    unique case (state_q)
      ptsa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ptsa_pkg::ST_EVAL;
        end
      end
      ptsa_pkg::ST_EVAL: begin
        if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ptsa_pkg::ST_DIV;
        end else begin
          state_d = ptsa_pkg::ST_DONE;
        end
      end
      ptsa_pkg::ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ptsa_pkg::ST_DONE;
        end
      end
      ptsa_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ptsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/pwm_timer_share_allocator.sv]
// Top level of the PWM timer share allocator: port packing, controller, datapath.
// Depends on ptsa_pkg, ptsa_ctrl and ptsa_datapath.
//
//   channel  | valid / ready               | payload
//   ---------+-----------------------------+--------------------------------------
//   request  | s_axis_tvalid_i / _tready_o | tuser: action; tdata: channel .. idle
//   result   | m_axis_tvalid_o / _tready_i | tuser: status; tdata: timer .. level
//   config   | cfg_valid_i / cfg_ready_o   | cfg_data_i: source clock in hertz
//
// An init that needs a new timer waits for the restoring divider (one quotient
// bit per cycle) before its result; every other request skips the division.
// One request is in work at a time.
// The result register frees the request side while a result waits.
// Reset clears all timers and channels and loads the 40 MHz source clock.
module pwm_timer_share_allocator #(
  parameter int NUM_TIMERS   = 4,
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // channel, freq_hz, res_bits, duty, idle_high
  input  logic [1:0]  s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // timer_index, new_timer, divider, duty_word,
                                       // max_duty, stop_level
  output logic [1:0]  m_axis_tuser_o,  // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [26:0] cfg_data_i       // source_clock_hz
);

  ptsa_pkg::ptsa_cmd_t    cmd;
  ptsa_pkg::ptsa_stat_t   stat;
  ptsa_pkg::ptsa_status_e status;
  logic [ptsa_pkg::TIDX_W-1:0]  timer_index;
  logic                         new_timer;
  logic [ptsa_pkg::DIV_W-1:0]   divider;
  logic [ptsa_pkg::DWORD_W-1:0] duty_word;
  logic [ptsa_pkg::MAXD_W-1:0]  max_duty;
  logic                         stop_level;

  // Configuration writes are taken at any time
  assign cfg_ready_o = 1'b1;

  ptsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptsa_datapath #(
    .NUM_TIMERS   (NUM_TIMERS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (s_axis_tuser_i),
    .channel_i     (s_axis_tdata_i[3:0]),
    .freq_hz_i     (s_axis_tdata_i[29:4]),
    .res_bits_i    (s_axis_tdata_i[33:30]),
    .duty_i        (s_axis_tdata_i[49:34]),
    .idle_high_i   (s_axis_tdata_i[50]),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .status_o      (status),
    .timer_index_o (timer_index),
    .new_timer_o   (new_timer),
    .divider_o     (divider),
    .duty_word_o   (duty_word),
    .max_duty_o    (max_duty),
    .stop_level_o  (stop_level)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tuser_o = status;
  assign m_axis_tdata_o = {stop_level, max_duty, duty_word, divider, new_timer, timer_index};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the PWM timer share allocator: drives requests, predicts results.
// Depends on ptsa_pkg and pwm_timer_share_allocator; needs nothing else.
module tb_top;

  localparam int NUM_TIMERS   = 4;
  localparam int NUM_CHANNELS = 8;
  localparam logic [ptsa_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam longint unsigned DIV_LOW  = 64'd256;
  localparam longint unsigned DIV_HIGH = 64'd262143;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [ptsa_pkg::ACT_W-1:0]  act;
    logic [ptsa_pkg::CHAN_W-1:0] ch;
    logic [ptsa_pkg::FREQ_W-1:0] freq;
    logic [ptsa_pkg::RES_W-1:0]  res;
    logic [ptsa_pkg::DUTY_W-1:0] duty;
    logic                        idle;
  } alloc_req_t;

  typedef struct packed {
    ptsa_pkg::ptsa_status_e        status;
    logic [ptsa_pkg::TIDX_W-1:0]   tidx;
    logic                          fresh;
    logic [ptsa_pkg::DIV_W-1:0]    divider;
    logic [ptsa_pkg::DWORD_W-1:0]  dword;
    logic [ptsa_pkg::MAXD_W-1:0]   maxd;
    logic                          level;
  } alloc_res_t;

  // Mirror of the allocator: timer table, channel resolutions and expected results
  class timer_alloc_tracker;
    logic [ptsa_pkg::SRC_W-1:0]  src_hz;
    logic [ptsa_pkg::FREQ_W-1:0] tmr_freq [NUM_TIMERS];
    logic [ptsa_pkg::RES_W-1:0]  tmr_res  [NUM_TIMERS];
    bit                          tmr_used [NUM_TIMERS];
    logic [ptsa_pkg::RES_W-1:0]  chan_res [NUM_CHANNELS];
    alloc_res_t                  pending_results [$];
    int                          errors;
    int                          checked;
    int                          claims;
    int                          by_status [4];

    function new();
      src_hz = ptsa_pkg::SRC_RESET;
      foreach (tmr_used[t]) begin
        tmr_freq[t] = '0;
        tmr_res[t]  = '0;
        tmr_used[t] = 1'b0;
      end
      foreach (chan_res[c]) chan_res[c] = '0;
      errors  = 0;
      checked = 0;
      claims  = 0;
      foreach (by_status[s]) by_status[s] = 0;
    endfunction

    // Work out the result of one accepted request and update the mirror
    function void note_request(alloc_req_t r);
      alloc_res_t e;
      bit hit;
      longint unsigned quo;
      longint unsigned cap;
      longint unsigned d;
      e = '0;
      e.status = ptsa_pkg::STAT_BAD;
      hit = 1'b0;
      case (r.act)
        ptsa_pkg::ACT_INIT: begin
          if (r.ch < NUM_CHANNELS && r.freq != 0 && r.res != 0
              && r.res <= ptsa_pkg::MAX_RES) begin
            // reuse a running timer with the same setting
            for (int t = 0; t < NUM_TIMERS; t++) begin
              if (!hit && tmr_used[t] && tmr_freq[t] == r.freq && tmr_res[t] == r.res) begin
                hit = 1'b1;
                chan_res[r.ch[2:0]] = r.res;
                e.tidx   = ptsa_pkg::TIDX_W'(t);
                e.status = ptsa_pkg::STAT_OK;
              end
            end
            if (!hit) begin
              quo = (longint'(src_hz) << ptsa_pkg::FRAC_BITS)
                    / (longint'(r.freq) << r.res);
              e.status = ptsa_pkg::STAT_NOFIT;
              if (quo >= DIV_LOW && quo <= DIV_HIGH) begin
                // claim the lowest free timer
                for (int t = 0; t < NUM_TIMERS; t++) begin
                  if (!hit && !tmr_used[t]) begin
                    hit = 1'b1;
                    tmr_used[t] = 1'b1;
                    tmr_freq[t] = r.freq;
                    tmr_res[t]  = r.res;
                    chan_res[r.ch[2:0]] = r.res;
                    e.tidx    = ptsa_pkg::TIDX_W'(t);
                    e.fresh   = 1'b1;
                    e.divider = ptsa_pkg::DIV_W'(quo);
                    e.status  = ptsa_pkg::STAT_OK;
                    claims++;
                  end
                end
              end
            end
          end
        end
        ptsa_pkg::ACT_DUTY: begin
          if (r.ch >= NUM_CHANNELS) begin
            e.status = ptsa_pkg::STAT_BAD;
          end else if (chan_res[r.ch[2:0]] == 0) begin
            e.status = ptsa_pkg::STAT_IDLE;
          end else begin
            cap = 64'd1 << chan_res[r.ch[2:0]];
            d = (longint'(r.duty) > cap) ? cap : longint'(r.duty);
            e.dword  = ptsa_pkg::DWORD_W'(d << ptsa_pkg::DUTY_FRAC);
            e.status = ptsa_pkg::STAT_OK;
          end
        end
        ptsa_pkg::ACT_STOP: begin
          if (r.ch < NUM_CHANNELS) begin
            e.status = ptsa_pkg::STAT_OK;
            e.level  = r.idle;
          end
        end
        default: e.status = ptsa_pkg::STAT_BAD;
      endcase
      if (r.ch < NUM_CHANNELS && chan_res[r.ch[2:0]] != 0)
        e.maxd = ptsa_pkg::MAXD_W'(64'd1 << chan_res[r.ch[2:0]]);
      pending_results.push_back(e);
    endfunction

    function void compare(string name, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_result(logic [1:0] st, logic [55:0] d);
      alloc_res_t e;
      if (pending_results.size() == 0) begin
        $error("result with status %0d arrived with none outstanding", st);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      checked++;
      by_status[e.status]++;
      compare("status", e.status, st);
      compare("timer_index", e.tidx, d[1:0]);
      compare("new_timer", e.fresh, d[2]);
      compare("divider", e.divider, d[20:3]);
      compare("duty_word", e.dword, d[39:21]);
      compare("max_duty", e.maxd, d[54:40]);
      compare("stop_level", e.level, d[55]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [26:0] cfg_data_i = '0;

  timer_alloc_tracker tracker = new();
  bit no_gaps = 1'b0;
  int stall_left = 0;
  int stall_len = 0;
  int cfg_writes = 0;

  pwm_timer_share_allocator #(
    .NUM_TIMERS  (NUM_TIMERS),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Result side: check accepted results, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_result(m_axis_tuser_o, m_axis_tdata_o);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      stall_len = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (stall_len > 0) begin
        stall_left <= stall_len - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Present one request after a random gap; hold valid high afterwards
  task automatic send_request(alloc_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.act;
    s_axis_tdata_i  <= {5'b0, r.idle, r.duty, r.res, r.freq, r.ch};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_request(r);
  endtask

  task automatic send(logic [ptsa_pkg::ACT_W-1:0] act, logic [ptsa_pkg::CHAN_W-1:0] ch,
                      logic [ptsa_pkg::FREQ_W-1:0] freq, logic [ptsa_pkg::RES_W-1:0] res,
                      logic [ptsa_pkg::DUTY_W-1:0] duty, logic idle);
    alloc_req_t r;
    r = '{act: act, ch: ch, freq: freq, res: res, duty: duty, idle: idle};
    send_request(r);
  endtask

  // Drop valid and wait until every result is back and the block has settled
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_source_clock(logic [ptsa_pkg::SRC_W-1:0] hz);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.src_hz = hz;
    cfg_writes++;
  endtask

  // Random requests: mostly well-formed inits, duty updates and stops
  task automatic run_random(int count);
    alloc_req_t r;
    int kind;
    int sub;
    int t;
    longint unsigned step;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r.act  = ptsa_pkg::ACT_INIT;
      r.ch   = ptsa_pkg::CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
      r.freq = ptsa_pkg::FREQ_W'($urandom);
      r.res  = ptsa_pkg::RES_W'($urandom);
      r.duty = ptsa_pkg::DUTY_W'($urandom);
      r.idle = 1'($urandom);
      kind = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      if (kind < 30) begin
        t = $urandom_range(0, NUM_TIMERS - 1);
        if (sub < 40 && tracker.tmr_used[t]) begin
          // same setting as a running timer
          r.freq = tracker.tmr_freq[t];
          r.res  = tracker.tmr_res[t];
        end else if (sub < 75) begin
          // setting meant to land the divider in range
          r.res = ptsa_pkg::RES_W'($urandom_range(1, ptsa_pkg::MAX_RES));
          step = (64'd1 << r.res) * longint'($urandom_range(1, 1023));
          r.freq = ptsa_pkg::FREQ_W'(longint'(tracker.src_hz) / step);
          if (r.freq == 0) r.freq = 1;
        end else begin
          r.ch = ptsa_pkg::CHAN_W'($urandom);
          if (sub < 82) r.freq = '0;
        end
      end else if (kind < 70) begin
        r.act = ptsa_pkg::ACT_DUTY;
        if (sub < 10) r.ch = ptsa_pkg::CHAN_W'($urandom);
        else if (sub < 45)
          r.duty = ptsa_pkg::DUTY_W'((32'd1 << tracker.chan_res[r.ch[2:0]])
                                     + $urandom_range(0, 2) - 1);
        else if (sub < 55) r.duty = (sub < 50) ? '1 : '0;
      end else if (kind < 90) begin
        r.act = ptsa_pkg::ACT_STOP;
        if (sub < 15) r.ch = ptsa_pkg::CHAN_W'($urandom);
      end else begin
        r.act = (sub < 60) ? ACT_UNUSED : ptsa_pkg::ACT_W'($urandom);
        r.ch  = ptsa_pkg::CHAN_W'($urandom);
      end
      send_request(r);
    end
  endtask

  // Main sequence
  initial begin
    logic [ptsa_pkg::SRC_W-1:0] phase_hz [7];
    phase_hz = '{ptsa_pkg::SRC_W'(80000000), ptsa_pkg::SRC_W'(1),
                 ptsa_pkg::SRC_W'($urandom_range(1, 80000000)), ptsa_pkg::SRC_W'(0),
                 ptsa_pkg::SRC_W'($urandom_range(1, 80000000)),
                 ptsa_pkg::SRC_W'(12345678), ptsa_pkg::SRC_W'(40000000)};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset source clock of 40 MHz
    send(ptsa_pkg::ACT_INIT, 4'd8, 26'd1000, 4'd10, 16'd0, 1'b0);     // channel out of range
    send(ptsa_pkg::ACT_INIT, 4'd0, 26'd0, 4'd10, 16'd0, 1'b0);        // zero frequency
    send(ptsa_pkg::ACT_INIT, 4'd0, 26'd1000, 4'd0, 16'd0, 1'b0);      // zero resolution
    send(ptsa_pkg::ACT_INIT, 4'd0, 26'd1000, 4'd15, 16'd0, 1'b0);     // resolution too wide
    send(ptsa_pkg::ACT_DUTY, 4'd0, 26'd0, 4'd0, 16'd100, 1'b0);       // channel not started
    send(ptsa_pkg::ACT_DUTY, 4'd15, 26'd0, 4'd0, 16'd100, 1'b0);      // channel out of range
    send(ptsa_pkg::ACT_STOP, 4'd15, 26'd0, 4'd0, 16'd0, 1'b1);        // stop out of range
    send(ptsa_pkg::ACT_STOP, 4'd0, 26'd0, 4'd0, 16'd0, 1'b1);         // stop before start
    send(ACT_UNUSED, 4'd0, 26'd1000, 4'd10, 16'hFFFF, 1'b1);          // unused action code
    send(ptsa_pkg::ACT_INIT, 4'd0, 26'd1000, 4'd10, 16'd0, 1'b0);     // first timer claimed
    send(ptsa_pkg::ACT_INIT, 4'd1, 26'd1000, 4'd10, 16'd0, 1'b0);     // shared timer
    send(ptsa_pkg::ACT_INIT, 4'd0, 26'd1, 4'd1, 16'd0, 1'b0);         // divider too large
    send(ptsa_pkg::ACT_INIT, 4'd2, 26'h3FFFFFF, 4'd14, 16'd0, 1'b0);  // divider too small
    send(ptsa_pkg::ACT_DUTY, 4'd2, 26'd0, 4'd0, 16'd5, 1'b0);         // failed init left it idle
    send(ptsa_pkg::ACT_INIT, 4'd2, 26'd20000000, 4'd1, 16'd0, 1'b0);  // divider at its floor
    send(ptsa_pkg::ACT_INIT, 4'd3, 26'd19532, 4'd1, 16'd0, 1'b0);     // divider near its ceiling
    send(ptsa_pkg::ACT_DUTY, 4'd0, 26'd0, 4'd0, 16'hFFFF, 1'b0);      // clamp to full scale
    send(ptsa_pkg::ACT_DUTY, 4'd0, 26'd0, 4'd0, 16'd0, 1'b0);
    send(ptsa_pkg::ACT_DUTY, 4'd1, 26'd0, 4'd0, 16'd1023, 1'b0);
    send(ptsa_pkg::ACT_DUTY, 4'd1, 26'd0, 4'd0, 16'd1024, 1'b0);
    send(ptsa_pkg::ACT_DUTY, 4'd2, 26'h3FFFFFF, 4'hF, 16'd3, 1'b1);
    send(ptsa_pkg::ACT_STOP, 4'd0, 26'd0, 4'd0, 16'd0, 1'b0);
    send(ptsa_pkg::ACT_STOP, 4'd7, 26'h3FFFFFF, 4'hF, 16'hFFFF, 1'b1);
    send(ptsa_pkg::ACT_DUTY, 4'd0, 26'd0, 4'd0, 16'd9, 1'b0);         // stop kept resolution

    // Random part across several source clock settings
    foreach (phase_hz[p]) begin
      write_source_clock(phase_hz[p]);
      run_random(100);
    end
    drain();

    $display("Checked %0d results (ok %0d, bad %0d, no fit %0d, not started %0d)",
             tracker.checked, tracker.by_status[ptsa_pkg::STAT_OK],
             tracker.by_status[ptsa_pkg::STAT_BAD],
             tracker.by_status[ptsa_pkg::STAT_NOFIT],
             tracker.by_status[ptsa_pkg::STAT_IDLE]);
    $display("Timers claimed: %0d; source clock writes: %0d", tracker.claims, cfg_writes);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[pwm_timer_share_allocator.f]
sv/ptsa_pkg.sv
sv/ptsa_div.sv
sv/ptsa_datapath.sv
sv/ptsa_ctrl.sv
sv/pwm_timer_share_allocator.sv
tb/tb_top.sv
